// ===== src/qse_pkg.sv =====
// qse_pkg: shared types and constants for the quicksort engine.
// No dependencies; imported by qse_ctrl and quicksort_engine.
package qse_pkg;

  localparam int DATA_W = 32;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP,
    S_POP_WAIT,
    S_PIVOT,
    S_SCAN_I,
    S_I_WAIT,
    S_SCAN_J,
    S_J_WAIT,
    S_SWAP,
    S_PUSH_LO,
    S_PUSH_HI,
    S_EMIT
  } qse_state_t;

endpackage

// ===== src/quicksort_engine.sv =====
// quicksort_engine: collects signed values, sorts them with quicksort
// (middle pivot, Hoare partition), emits them in ascending order.
// Load: one item per cycle while busy is low; an item with last high starts the sort.
// Sort: speed is set by the single read port of the element RAM; each scanned element
// is addressed in a scan step and compared with the pivot in its wait step.
// Emit: one result per cycle, flagged by strobe; no stall.
// Reset (rst, synchronous) clears count, overflow flag and sequencer; RAMs are not cleared.
module quicksort_engine
  import qse_pkg::*;
#(
  parameter int MAX_ELEMS = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     last,
  output logic                     strobe,
  output logic signed [DATA_W-1:0] sorted_value,
  output logic                     last_out,
  output logic                     overflowed
);

  localparam int IW      = (MAX_ELEMS > 2) ? $clog2(MAX_ELEMS) : 1;
  localparam int CW      = $clog2(MAX_ELEMS + 1);
  localparam int STACK_D = MAX_ELEMS / 2;
  localparam int SAW     = (STACK_D > 1) ? $clog2(STACK_D) : 1;
  localparam int SPW     = $clog2(STACK_D + 1) + 1;

  logic              e_we, s_we;
  logic [IW-1:0]     e_waddr, e_raddr;
  logic [DATA_W-1:0] e_wdata, e_rdata;
  logic [SAW-1:0]    s_waddr, s_raddr;
  logic [2*IW-1:0]   s_wdata, s_rdata;

  qse_ram #(
    .DEPTH (MAX_ELEMS),
    .WIDTH (DATA_W),
    .AW    (IW)
  ) u_elem_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  qse_ram #(
    .DEPTH (STACK_D),
    .WIDTH (2 * IW),
    .AW    (SAW)
  ) u_stack_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  qse_ctrl #(
    .MAX_ELEMS (MAX_ELEMS),
    .IW        (IW),
    .CW        (CW),
    .STACK_D   (STACK_D),
    .SAW       (SAW),
    .SPW       (SPW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value      (value),
    .last       (last),
    .strobe     (strobe),
    .last_out   (last_out),
    .overflowed (overflowed),
    .e_we       (e_we),
    .e_waddr    (e_waddr),
    .e_wdata    (e_wdata),
    .e_raddr    (e_raddr),
    .e_rdata    (signed'(e_rdata)),
    .s_we       (s_we),
    .s_waddr    (s_waddr),
    .s_wdata    (s_wdata),
    .s_raddr    (s_raddr),
    .s_rdata    (s_rdata)
  );

  assign sorted_value = signed'(e_rdata);

endmodule

// ===== src/qse_ram.sv =====
// qse_ram: simple dual-port synchronous RAM, one write and one read port,
// read data registered. No dependencies.
module qse_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/qse_ctrl.sv =====
// qse_ctrl: load, quicksort sequencer and emit logic of the quicksort engine.
// Depends on qse_pkg; drives the element RAM and the range stack RAM.
module qse_ctrl
  import qse_pkg::*;
#(
  parameter int MAX_ELEMS = 64,
  parameter int IW        = 6,
  parameter int CW        = 7,
  parameter int STACK_D   = 32,
  parameter int SAW       = 5,
  parameter int SPW       = 6
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     last,
  output logic                     strobe,
  output logic                     last_out,
  output logic                     overflowed,
  output logic                     e_we,
  output logic [IW-1:0]            e_waddr,
  output logic [DATA_W-1:0]        e_wdata,
  output logic [IW-1:0]            e_raddr,
  input  logic signed [DATA_W-1:0] e_rdata,
  output logic                     s_we,
  output logic [SAW-1:0]           s_waddr,
  output logic [2*IW-1:0]          s_wdata,
  output logic [SAW-1:0]           s_raddr,
  input  logic [2*IW-1:0]          s_rdata
);

  localparam int XW = IW + 2;

  qse_state_t state, state_next;
  logic [CW-1:0]            count, count_next;
  logic                     ovf, ovf_next;
  logic [SPW-1:0]           sp, sp_next;
  logic [IW-1:0]            lo, lo_next, hi, hi_next, k, k_next;
  logic signed [XW-1:0]     i, i_next, j, j_next;
  logic signed [DATA_W-1:0] pivot, pivot_next, ai, ai_next;
  logic                     strobe_next, last_out_next, overflowed_next;

  logic signed [XW-1:0] lo_s, hi_s, i_inc, j_dec;
  logic [CW-1:0]        cnt_inc;
  logic [IW-1:0]        pop_lo, pop_hi;
  logic [IW:0]          mid_sum;

  assign lo_s    = signed'({2'b00, lo});
  assign hi_s    = signed'({2'b00, hi});
  assign i_inc   = i + XW'(1);
  assign j_dec   = j - XW'(1);
  assign cnt_inc = count + CW'(1);
  assign pop_lo  = s_rdata[2*IW-1:IW];
  assign pop_hi  = s_rdata[IW-1:0];
  assign mid_sum = {1'b0, pop_lo} + {1'b0, pop_hi};
  assign busy    = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      ovf        <= 1'b0;
      sp         <= '0;
      strobe     <= 1'b0;
      last_out   <= 1'b0;
      overflowed <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      ovf        <= ovf_next;
      sp         <= sp_next;
      strobe     <= strobe_next;
      last_out   <= last_out_next;
      overflowed <= overflowed_next;
    end
    lo    <= lo_next;
    hi    <= hi_next;
    k     <= k_next;
    i     <= i_next;
    j     <= j_next;
    pivot <= pivot_next;
    ai    <= ai_next;
  end

  always_comb begin
    logic [CW-1:0] n;
    state_next      = state;
    count_next      = count;
    ovf_next        = ovf;
    sp_next         = sp;
    lo_next         = lo;
    hi_next         = hi;
    k_next          = k;
    i_next          = i;
    j_next          = j;
    pivot_next      = pivot;
    ai_next         = ai;
    strobe_next     = 1'b0;
    last_out_next   = 1'b0;
    overflowed_next = 1'b0;
    e_we            = 1'b0;
    e_waddr         = '0;
    e_wdata         = '0;
    e_raddr         = '0;
    s_we            = 1'b0;
    s_waddr         = '0;
    s_wdata         = '0;
    s_raddr         = '0;
    n               = count;

    case (state)
      S_IDLE: begin
        if (start) begin
          if (count < CW'(MAX_ELEMS)) begin
            e_we    = 1'b1;
            e_waddr = count[IW-1:0];
            e_wdata = value;
            n       = cnt_inc;
          end else begin
            ovf_next = 1'b1;
          end
          count_next = n;
          if (last) begin
            k_next = '0;
            if (n < CW'(2)) begin
              state_next = S_EMIT;
            end else begin
              s_we       = 1'b1;
              s_waddr    = '0;
              s_wdata    = {IW'(0), IW'(n - CW'(1))};
              sp_next    = SPW'(1);
              state_next = S_POP;
            end
          end
        end
      end
      S_POP: begin
        if (sp == '0) begin
          k_next     = '0;
          state_next = S_EMIT;
        end else begin
          s_raddr    = SAW'(sp - SPW'(1));
          sp_next    = sp - SPW'(1);
          state_next = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        lo_next = pop_lo;
        hi_next = pop_hi;
        i_next  = signed'({2'b00, pop_lo});
        j_next  = signed'({2'b00, pop_hi});
        if (pop_lo >= pop_hi || CW'(pop_hi) >= count) begin
          state_next = S_POP;
        end else begin
          e_raddr    = mid_sum[IW:1];
          state_next = S_PIVOT;
        end
      end
      S_PIVOT: begin
        pivot_next = e_rdata;
        state_next = S_SCAN_I;
      end
      S_SCAN_I: begin
        e_raddr    = i[IW-1:0];
        state_next = S_I_WAIT;
      end
      S_I_WAIT: begin
        if (i < hi_s && e_rdata < pivot) begin
          i_next     = i_inc;
          state_next = S_SCAN_I;
        end else begin
          ai_next    = e_rdata;
          state_next = S_SCAN_J;
        end
      end
      S_SCAN_J: begin
        e_raddr    = j[IW-1:0];
        state_next = S_J_WAIT;
      end
      S_J_WAIT: begin
        if (j > lo_s && e_rdata > pivot) begin
          j_next     = j_dec;
          state_next = S_SCAN_J;
        end else if (i <= j) begin
          e_we       = 1'b1;
          e_waddr    = i[IW-1:0];
          e_wdata    = e_rdata;
          state_next = S_SWAP;
        end else begin
          state_next = S_PUSH_LO;
        end
      end
      S_SWAP: begin
        e_we    = 1'b1;
        e_waddr = j[IW-1:0];
        e_wdata = ai;
        i_next  = i_inc;
        j_next  = j_dec;
        if (i_inc <= j_dec) begin
          state_next = S_SCAN_I;
        end else begin
          state_next = S_PUSH_LO;
        end
      end
      S_PUSH_LO: begin
        if (lo_s < j && sp < SPW'(STACK_D)) begin
          s_we    = 1'b1;
          s_waddr = sp[SAW-1:0];
          s_wdata = {lo, j[IW-1:0]};
          sp_next = sp + SPW'(1);
        end
        state_next = S_PUSH_HI;
      end
      S_PUSH_HI: begin
        if (i < hi_s && sp < SPW'(STACK_D)) begin
          s_we    = 1'b1;
          s_waddr = sp[SAW-1:0];
          s_wdata = {i[IW-1:0], hi};
          sp_next = sp + SPW'(1);
        end
        state_next = S_POP;
      end
      S_EMIT: begin
        e_raddr         = k;
        strobe_next     = 1'b1;
        overflowed_next = ovf;
        if (CW'(k) == count - CW'(1)) begin
          last_out_next = 1'b1;
          count_next    = '0;
          ovf_next      = 1'b0;
          state_next    = S_IDLE;
        end else begin
          k_next = k + IW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_strobe_from_emit: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state) == S_EMIT)
    else $error("result strobe without emit step");

  a_last_has_strobe: assert property (@(posedge clk) disable iff (rst)
    last_out |-> strobe)
    else $error("last_out without strobe");

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SPW'(STACK_D))
    else $error("range stack pointer out of range");

  a_scan_i_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN_I |-> (i <= hi_s && i >= lo_s))
    else $error("left scan index outside partition");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ELEMS))
    else $error("element count above capacity");

endmodule
